>>> hdl/ldp_pkg.sv
// Package for the lattice domain partitioner.
// Holds the widths, the sequencer state type and the divider request/response structs.
// No dependencies.
package ldp_pkg;

  localparam int MAX_PARTS = 64;
  localparam int DIM_W     = 16;
  localparam int PART_W    = $clog2(MAX_PARTS + 1);
  localparam int IDX_W     = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int ALN_W     = 7;
  localparam int LENX_W    = DIM_W + 1;
  localparam int DVD_W     = DIM_W + 1;
  localparam int DVS_W     = (ALN_W > PART_W) ? ALN_W : PART_W;
  localparam int CNT_W     = $clog2(DVD_W + 1);
  localparam int MUL_A_W   = DIM_W + 1;
  localparam int PONE_W    = $clog2(MAX_PARTS + 2);
  localparam int MUL_B_W   = (ALN_W > PONE_W) ? ALN_W : PONE_W;
  localparam int COST_W    = MUL_A_W + MUL_B_W;

  localparam logic [ALN_W-1:0] X_ALIGN_RST = ALN_W'(16);

  typedef enum logic [3:0] {
    S_IDLE,
    S_XDIV,
    S_XMUL,
    S_BINIT,
    S_PDIV,
    S_CMUL1,
    S_CMUL2,
    S_CMP,
    S_ZDIV,
    S_YDIV,
    S_OUT,
    S_NOFIT
  } ldp_state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } ldp_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } ldp_div_rsp_t;

endpackage

>>> hdl/ldp_if.sv
// Channel interfaces of the lattice domain partitioner: request word in, part word out.
// Depends on ldp_pkg for the field widths.
interface ldp_req_if;
  import ldp_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIM_W-1:0]  size_x;
  logic [DIM_W-1:0]  size_y;
  logic [DIM_W-1:0]  size_z;
  logic [PART_W-1:0] part_count;

  modport source (output valid, size_x, size_y, size_z, part_count, input ready);
  modport sink   (input valid, size_x, size_y, size_z, part_count, output ready);
endinterface

interface ldp_part_if;
  import ldp_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  part_index;
  logic [DIM_W-1:0]  offset_y;
  logic [DIM_W-1:0]  offset_z;
  logic [LENX_W-1:0] len_x;
  logic [DIM_W-1:0]  len_y;
  logic [DIM_W-1:0]  len_z;
  logic [PART_W-1:0] slabs_y;
  logic [PART_W-1:0] slabs_z;
  logic              fitted;
  logic              last;

  modport source (output valid, part_index, offset_y, offset_z, len_x, len_y, len_z,
                  slabs_y, slabs_z, fitted, last, input ready);
  modport sink   (input valid, part_index, offset_y, offset_z, len_x, len_y, len_z,
                  slabs_y, slabs_z, fitted, last, output ready);
endinterface

>>> hdl/lattice_domain_partitioner.sv
// Lattice domain partitioner: splits a 3D mesh into Y/Z slabs for a part count.
// Every division runs on the shared divider, which yields 17 quotient bits.
// A request of P parts divides for the X alignment, tries each Z slab count up to P with
// a cost check on every divisor of P, then divides once per Z slab and once per part;
// when nothing fits it emits P unfitted part words. Ready only when idle.
// Reset (async, active low) returns the sequencer to idle and sets x_align to 16.
module lattice_domain_partitioner (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      x_align_we_i,
  input  logic [ldp_pkg::ALN_W-1:0] x_align_i,
  ldp_req_if.sink                   req_i,
  ldp_part_if.source                part_o
);
  import ldp_pkg::*;

  ldp_state_e state_q, state_d;
  logic       div_start_q, div_start_d;
  logic [ALN_W-1:0] x_align_q;

  logic [DIM_W-1:0]  nx_q, nx_d, ny_q, ny_d, nz_q, nz_d;
  logic [PART_W-1:0] parts_q, parts_d;
  logic [LENX_W-1:0] aligned_x_q, aligned_x_d;
  logic [COST_W-1:0] best_q, best_d, acc_q, acc_d, acc2_q, acc2_d;
  logic [PART_W-1:0] dz_q, dz_d, dy_q, dy_d, by_q, by_d, bz_q, bz_d;
  logic              have_q, have_d;
  logic [IDX_W-1:0]  k_q, k_d, iz_q, iz_d, jy_q, jy_d;
  logic [DIM_W-1:0]  remz_q, remz_d, remy_q, remy_d;
  logic [DIM_W-1:0]  lenz_q, lenz_d, leny_q, leny_d;
  logic [DIM_W-1:0]  oy_q, oy_d, oz_q, oz_d;

  ldp_div_req_t div_req;
  ldp_div_rsp_t div_rsp;

  logic              in_acc, out_acc;
  logic [PART_W-1:0] parts_in;
  logic [ALN_W-1:0]  align;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [COST_W-1:0] prod;
  logic [COST_W-1:0] cost;
  logic              cost_lt, fits, fit_hit;
  logic              search_end, last_part, y_wrap;
  logic              is_fit;

  assign in_acc   = req_i.valid && req_i.ready;
  assign out_acc  = part_o.valid && part_o.ready;
  assign parts_in = (req_i.part_count > PART_W'(MAX_PARTS)) ? PART_W'(MAX_PARTS)
                                                            : req_i.part_count;
  assign align    = (x_align_q == '0) ? ALN_W'(1) : x_align_q;

  // Search bookkeeping
  assign cost       = acc_q + acc2_q;
  assign cost_lt    = cost < best_q;
  assign fits       = (nz_q >= DIM_W'(dz_q)) && (ny_q >= DIM_W'(dy_q));
  assign fit_hit    = (state_q == S_CMP) && cost_lt && fits;
  assign search_end = dz_q == parts_q;
  assign last_part  = (PART_W'(k_q) + PART_W'(1)) == parts_q;
  assign y_wrap     = (PART_W'(jy_q) + PART_W'(1)) == by_q;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_XMUL: begin
        mul_a = div_rsp.quot;
        mul_b = MUL_B_W'(align);
      end
      S_BINIT: begin
        mul_a = MUL_A_W'(ny_q) + MUL_A_W'(nz_q);
        mul_b = MUL_B_W'(parts_q) + MUL_B_W'(1);
      end
      S_CMUL1: begin
        mul_a = MUL_A_W'(ny_q);
        mul_b = MUL_B_W'(dz_q);
      end
      S_CMUL2: begin
        mul_a = MUL_A_W'(nz_q);
        mul_b = MUL_B_W'(dy_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = COST_W'(mul_a) * COST_W'(mul_b);

  // Divider operand select
  always_comb begin
    div_req.start    = div_start_q;
    div_req.dividend = '0;
    div_req.divisor  = DVS_W'(1);
    unique case (state_q)
      S_XDIV: begin
        div_req.dividend = DVD_W'(nx_q) + DVD_W'(align) - DVD_W'(1);
        div_req.divisor  = DVS_W'(align);
      end
      S_PDIV: begin
        div_req.dividend = DVD_W'(parts_q);
        div_req.divisor  = DVS_W'(dz_q);
      end
      S_ZDIV: begin
        div_req.dividend = DVD_W'(remz_q);
        div_req.divisor  = DVS_W'(bz_q - PART_W'(iz_q));
      end
      S_YDIV: begin
        div_req.dividend = DVD_W'(remy_q);
        div_req.divisor  = DVS_W'(by_q - PART_W'(jy_q));
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = DVS_W'(1);
      end
    endcase
  end

  ldp_div u_ldp_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (parts_in != '0)) state_d = S_XDIV;
      end
      S_XDIV: begin
        if (div_rsp.done) state_d = S_XMUL;
      end
      S_XMUL:  state_d = S_BINIT;
      S_BINIT: state_d = S_PDIV;
      S_PDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) state_d = S_CMUL1;
          else if (search_end)   state_d = have_q ? S_ZDIV : S_NOFIT;
          else                   state_d = S_PDIV;
        end
      end
      S_CMUL1: state_d = S_CMUL2;
      S_CMUL2: state_d = S_CMP;
      S_CMP: begin
        if (search_end) state_d = (have_q || fit_hit) ? S_ZDIV : S_NOFIT;
        else            state_d = S_PDIV;
      end
      S_ZDIV: begin
        if (div_rsp.done) state_d = S_YDIV;
      end
      S_YDIV: begin
        if (div_rsp.done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          if (last_part)   state_d = S_IDLE;
          else if (y_wrap) state_d = S_ZDIV;
          else             state_d = S_YDIV;
        end
      end
      S_NOFIT: begin
        if (out_acc && last_part) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Kick the divider on entry to a divide state, or on a repeat of one
  always_comb begin
    div_start_d = ((state_d == S_XDIV) || (state_d == S_PDIV) ||
                   (state_d == S_ZDIV) || (state_d == S_YDIV)) &&
                  ((state_d != state_q) || div_rsp.done);
  end

  // Datapath updates
  always_comb begin
    nx_d = nx_q;  ny_d = ny_q;  nz_d = nz_q;
    parts_d     = parts_q;
    aligned_x_d = aligned_x_q;
    best_d = best_q;  acc_d = acc_q;  acc2_d = acc2_q;
    dz_d = dz_q;  dy_d = dy_q;  by_d = by_q;  bz_d = bz_q;
    have_d = have_q;
    k_d = k_q;  iz_d = iz_q;  jy_d = jy_q;
    remz_d = remz_q;  remy_d = remy_q;
    lenz_d = lenz_q;  leny_d = leny_q;
    oy_d = oy_q;  oz_d = oz_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          nx_d    = req_i.size_x;
          ny_d    = req_i.size_y;
          nz_d    = req_i.size_z;
          parts_d = parts_in;
        end
      end
      S_XMUL: aligned_x_d = prod[LENX_W-1:0];
      S_BINIT: begin
        best_d = prod;
        dz_d   = PART_W'(1);
        have_d = 1'b0;
        by_d   = '0;
        bz_d   = '0;
        k_d    = '0;
        iz_d   = '0;
        oz_d   = '0;
        remz_d = nz_q;
      end
      S_PDIV: begin
        if (div_rsp.done) begin
          dy_d = div_rsp.quot[PART_W-1:0];
          if ((div_rsp.rem != '0) && !search_end) dz_d = dz_q + PART_W'(1);
        end
      end
      S_CMUL1: acc_d  = prod;
      S_CMUL2: acc2_d = prod;
      S_CMP: begin
        if (cost_lt) begin
          best_d = cost;
          if (fits) begin
            by_d   = dy_q;
            bz_d   = dz_q;
            have_d = 1'b1;
          end
        end
        if (!search_end) dz_d = dz_q + PART_W'(1);
      end
      S_ZDIV: begin
        if (div_rsp.done) begin
          lenz_d = div_rsp.quot[DIM_W-1:0];
          remz_d = remz_q - div_rsp.quot[DIM_W-1:0];
          jy_d   = '0;
          oy_d   = '0;
          remy_d = ny_q;
        end
      end
      S_YDIV: begin
        if (div_rsp.done) begin
          leny_d = div_rsp.quot[DIM_W-1:0];
          remy_d = remy_q - div_rsp.quot[DIM_W-1:0];
        end
      end
      S_OUT: begin
        if (out_acc) begin
          k_d  = k_q + IDX_W'(1);
          oy_d = oy_q + leny_q;
          jy_d = jy_q + IDX_W'(1);
          if (y_wrap) begin
            iz_d = iz_q + IDX_W'(1);
            oz_d = oz_q + lenz_q;
          end
        end
      end
      S_NOFIT: begin
        if (out_acc) k_d = k_q + IDX_W'(1);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_start_q <= 1'b0;
      x_align_q   <= X_ALIGN_RST;
      have_q      <= 1'b0;
      dz_q        <= '0;
      k_q         <= '0;
      iz_q        <= '0;
      jy_q        <= '0;
      parts_q     <= '0;
    end else begin
      state_q     <= state_d;
      div_start_q <= div_start_d;
      if (x_align_we_i) x_align_q <= x_align_i;
      have_q      <= have_d;
      dz_q        <= dz_d;
      k_q         <= k_d;
      iz_q        <= iz_d;
      jy_q        <= jy_d;
      parts_q     <= parts_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    nx_q        <= nx_d;
    ny_q        <= ny_d;
    nz_q        <= nz_d;
    aligned_x_q <= aligned_x_d;
    best_q      <= best_d;
    acc_q       <= acc_d;
    acc2_q      <= acc2_d;
    dy_q        <= dy_d;
    by_q        <= by_d;
    bz_q        <= bz_d;
    remz_q      <= remz_d;
    remy_q      <= remy_d;
    lenz_q      <= lenz_d;
    leny_q      <= leny_d;
    oy_q        <= oy_d;
    oz_q        <= oz_d;
  end

  // Outputs: zero the geometry of a part word when no layout fitted
  always_comb begin
    is_fit            = state_q == S_OUT;
    req_i.ready       = state_q == S_IDLE;
    part_o.valid      = (state_q == S_OUT) || (state_q == S_NOFIT);
    part_o.part_index = k_q;
    part_o.last       = last_part;
    part_o.fitted     = is_fit;
    part_o.offset_y   = is_fit ? oy_q : '0;
    part_o.offset_z   = is_fit ? oz_q : '0;
    part_o.len_x      = is_fit ? aligned_x_q : '0;
    part_o.len_y      = is_fit ? leny_q : '0;
    part_o.len_z      = is_fit ? lenz_q : '0;
    part_o.slabs_y    = is_fit ? by_q : '0;
    part_o.slabs_z    = is_fit ? bz_q : '0;
  end

endmodule

>>> hdl/ldp_div.sv
// Shared restoring divider: one quotient bit per cycle, done rises once the last quotient bit is in.
// Depends on ldp_pkg for widths and the request/response structs.
module ldp_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ldp_pkg::ldp_div_req_t req_i,
  output ldp_pkg::ldp_div_rsp_t rsp_o
);
  import ldp_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_nx;
  logic             ge;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  // Load on start, else advance one bit while busy
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      rem_d = rem_nx[DVS_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> hdl/ldp_checker.sv
// Port-level checker for the lattice domain partitioner, attached by bind.
// Depends on ldp_pkg for widths and on the top level lattice_domain_partitioner.
module ldp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic [ldp_pkg::PART_W-1:0] req_part_count_i,
  input logic                      part_valid_i,
  input logic                      part_ready_i,
  input logic [ldp_pkg::IDX_W-1:0] part_index_i,
  input logic                      part_last_i,
  input logic                      part_fitted_i,
  input logic [ldp_pkg::LENX_W-1:0] part_len_x_i,
  input logic [ldp_pkg::DIM_W-1:0] part_len_y_i,
  input logic [ldp_pkg::DIM_W-1:0] part_len_z_i
);
  import ldp_pkg::*;

  // Hold a stalled part word
  a_part_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    part_valid_i && !part_ready_i |=> part_valid_i && $stable(part_index_i) &&
                                      $stable(part_last_i))
    else $error("part word changed while stalled");

  // Never take a request while parts are still being delivered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_i && part_valid_i))
    else $error("request side ready during part delivery");

  // Drop ready after taking a request that has parts
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_part_count_i != '0) |=> !req_ready_i)
    else $error("ready stayed high after a request with parts");

  // Run ends after the last part word
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    part_valid_i && part_ready_i && part_last_i |=> !part_valid_i)
    else $error("part word after the last one");

  // Fitted parts have nonzero Y/Z lengths, unfitted parts have all lengths zero
  a_fit_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    part_valid_i |-> (part_fitted_i && (part_len_y_i != '0) && (part_len_z_i != '0)) ||
                     (!part_fitted_i && (part_len_x_i == '0) && (part_len_y_i == '0) &&
                      (part_len_z_i == '0)))
    else $error("part extents disagree with fitted flag");

endmodule

bind lattice_domain_partitioner ldp_checker u_ldp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .req_part_count_i (req_i.part_count),
  .part_valid_i     (part_o.valid),
  .part_ready_i     (part_o.ready),
  .part_index_i     (part_o.part_index),
  .part_last_i      (part_o.last),
  .part_fitted_i    (part_o.fitted),
  .part_len_x_i     (part_o.len_x),
  .part_len_y_i     (part_o.len_y),
  .part_len_z_i     (part_o.len_z)
);
